### rtl/rrd_pkg.sv
// shared types and constants of the round-robin dispatcher
`default_nettype none

package rrd_pkg;

   // sizing
   localparam int MAX_JOBS = 64;
   localparam int JOB_W    = $clog2(MAX_JOBS);
   localparam int COUNT_W  = $clog2(MAX_JOBS + 1);
   localparam int BURST_W  = 16;

   // fixed field widths of the channels
   localparam int FUNC_W      = 2;
   localparam int QUANTUM_W   = 16;
   localparam int JOB_INDEX_W = 6;
   localparam int TIME_W      = 22;
   localparam int NOW_W       = 23;
   localparam int TOTAL_W     = 28;
   localparam int LEFT_W      = 7;

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD     = 2'd0,
      FUNC_DISPATCH = 2'd1,
      FUNC_CLEAR    = 2'd2
   } func_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   // one ready-queue entry
   typedef struct packed {
      logic [JOB_W-1:0]   idx;
      logic [BURST_W-1:0] rem;
      logic [BURST_W-1:0] burst;
   } job_entry_type;

   // per-cell control from the queue to a cell
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   // result beat held in the output register
   typedef struct packed {
      logic                   queue_empty;
      logic [JOB_INDEX_W-1:0] job_index;
      logic [TIME_W-1:0]      slice_start;
      logic [TIME_W-1:0]      slice_end;
      logic                   extends_previous;
      logic                   job_finished;
      logic [TIME_W-1:0]      completion_time;
      logic [TIME_W-1:0]      waiting_time;
      logic [TOTAL_W-1:0]     total_turnaround;
      logic [TOTAL_W-1:0]     total_waiting;
      logic [LEFT_W-1:0]      jobs_left;
   } rsp_beat_type;

endpackage

`default_nettype wire

### rtl/rrd_req_if.sv
// request channel: operation code and burst time
`default_nettype none

interface rrd_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrd_pkg::FUNC_W-1:0]  func;
   logic [rrd_pkg::BURST_W-1:0] burst_time;

   modport source (output valid, output func, output burst_time, input ready);
   modport sink (input valid, input func, input burst_time, output ready);
endinterface

`default_nettype wire

### rtl/rrd_rsp_if.sv
// response channel: one slice or load report per beat
`default_nettype none

interface rrd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            queue_empty;
   logic [rrd_pkg::JOB_INDEX_W-1:0] job_index;
   logic [rrd_pkg::TIME_W-1:0]      slice_start;
   logic [rrd_pkg::TIME_W-1:0]      slice_end;
   logic                            extends_previous;
   logic                            job_finished;
   logic [rrd_pkg::TIME_W-1:0]      completion_time;
   logic [rrd_pkg::TIME_W-1:0]      waiting_time;
   logic [rrd_pkg::TOTAL_W-1:0]     total_turnaround;
   logic [rrd_pkg::TOTAL_W-1:0]     total_waiting;
   logic [rrd_pkg::LEFT_W-1:0]      jobs_left;

   modport source (
      output valid, output queue_empty, output job_index, output slice_start,
      output slice_end, output extends_previous, output job_finished,
      output completion_time, output waiting_time, output total_turnaround,
      output total_waiting, output jobs_left, input ready
   );
   modport sink (
      input valid, input queue_empty, input job_index, input slice_start,
      input slice_end, input extends_previous, input job_finished,
      input completion_time, input waiting_time, input total_turnaround,
      input total_waiting, input jobs_left, output ready
   );
endinterface

`default_nettype wire

### rtl/rrd_csr_if.sv
// configuration write channel: time quantum
`default_nettype none

interface rrd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rrd_pkg::QUANTUM_W-1:0] time_quantum;

   modport source (output valid, output time_quantum, input ready);
   modport sink (input valid, input time_quantum, output ready);
endinterface

`default_nettype wire

### rtl/rrd_cell.sv
// one ready-queue cell: holds an entry, loads new data or takes its neighbor's
`default_nettype none

module rrd_cell (
   input  wire logic                   clock,
   input  wire rrd_pkg::cell_ctrl_type ctrl,
   input  wire rrd_pkg::job_entry_type push_data,
   input  wire rrd_pkg::job_entry_type next_data,
   output rrd_pkg::job_entry_type      data_out
);
   import rrd_pkg::*;

   job_entry_type entry_ff;
   job_entry_type entry_in;

   // a write at this slot wins over the shift toward the head
   always_comb begin
      priority if (ctrl.load) begin
         entry_in = push_data;
      end else if (ctrl.shift) begin
         entry_in = next_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;

endmodule

`default_nettype wire

### rtl/rrd_queue.sv
// ready queue as a row of cells shifting toward the head
`default_nettype none

module rrd_queue (
   input  wire logic                          clock,
   input  wire logic                          shift,
   input  wire logic                          push,
   input  wire logic [rrd_pkg::COUNT_W-1:0]   push_pos,
   input  wire rrd_pkg::job_entry_type        push_data,
   output rrd_pkg::job_entry_type             head
);
   import rrd_pkg::*;

   job_entry_type cell_q [MAX_JOBS];

   // each cell takes the slot's write or the entry of the cell behind it
   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      cell_ctrl_type ctrl;
      job_entry_type next_data;

      assign ctrl.shift = shift;
      assign ctrl.load  = push && (push_pos == COUNT_W'(i));

      if (i == MAX_JOBS - 1) begin : g_tail
         assign next_data = push_data;
      end else begin : g_mid
         assign next_data = cell_q[i + 1];
      end

      rrd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .push_data (push_data),
         .next_data (next_data),
         .data_out  (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

`default_nettype wire

### rtl/round_robin_dispatcher_core.sv
// top level of the round-robin dispatcher
//
// Channels: req_ch carries one operation per beat (load a job's burst time,
// dispatch one slice, or clear the job set); rsp_ch returns at most one beat
// per request; csr_ch writes the time quantum and is always ready.
// Loads are answered with the job's index; a dispatch is answered with the
// slice it ran or with queue_empty. Clears, ignored loads and unused codes
// give no beat.
// Sequencing: a request is taken in the idle state, which registers its
// operation and the first-step results; the commit state then writes the
// result to the output register once the output slot is free. The two
// states follow the two steps of a dispatch: slice arithmetic on the queue
// head, then the write-back that requeues the job into the row of cells.
// When the receiver stalls with a beat held, the block keeps the next result
// in its commit step and takes no new request until the beat leaves.
// Reset empties the queue, zeroes time and totals and sets the quantum to 1;
// a clear does the same but keeps the quantum.
`default_nettype none

module round_robin_dispatcher_core (
   input  wire logic  clock,
   input  wire logic  reset,
   rrd_req_if.sink    req_ch,
   rrd_rsp_if.source  rsp_ch,
   rrd_csr_if.sink    csr_ch
);
   import rrd_pkg::*;

   // control state
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   loaded_ff, loaded_in;
   logic [NOW_W-1:0]     now_ff, now_in;
   logic                 last_valid_ff, last_valid_in;
   logic [JOB_W-1:0]     last_job_ff, last_job_in;
   logic                 started_ff, started_in;
   logic [TOTAL_W-1:0]   sum_turn_ff, sum_turn_in;
   logic [TOTAL_W-1:0]   sum_wait_ff, sum_wait_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [BURST_W-1:0]   burst_ff, burst_in;
   logic [NOW_W-1:0]     run_now_ff, run_now_in;
   logic [BURST_W-1:0]   rem_left_ff, rem_left_in;
   rsp_beat_type         beat_ff, beat_in;

   // queue interface
   logic                 q_shift;
   logic                 q_push;
   logic [COUNT_W-1:0]   q_push_pos;
   job_entry_type        q_push_data;
   job_entry_type        head;

   // handshake and sequencing strobes
   logic                 accept;
   logic                 slot_free;
   logic                 commit_go;

   // slice arithmetic on the head entry
   logic [BURST_W-1:0]   run_len;
   logic [NOW_W-1:0]     burst_ext;
   logic [NOW_W-1:0]     wait_val;

   rrd_queue u_queue (
      .clock     (clock),
      .shift     (q_shift),
      .push      (q_push),
      .push_pos  (q_push_pos),
      .push_data (q_push_data),
      .head      (head)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ch.ready;

   // next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            state_in = accept ? ST_COMMIT : ST_IDLE;
         end
         ST_COMMIT: begin
            state_in = slot_free ? ST_IDLE : ST_COMMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            commit_go    = 1'b0;
         end
         ST_COMMIT: begin
            req_ch.ready = 1'b0;
            commit_go    = slot_free;
         end
         default: begin
            req_ch.ready = 1'b0;
            commit_go    = 1'b0;
         end
      endcase
   end

   // first step: run length, new time and remaining time of the head job, and the request's code and burst time
   always_comb begin
      run_len     = (quantum_ff < head.rem) ? quantum_ff : head.rem;
      run_now_in  = accept ? now_ff + NOW_W'(run_len) : run_now_ff;
      rem_left_in = accept ? head.rem - run_len : rem_left_ff;
      func_in     = accept ? req_ch.func : func_ff;
      burst_in    = accept ? req_ch.burst_time : burst_ff;
   end

   // waiting time of a job that finishes in this slice
   always_comb begin
      burst_ext = NOW_W'(head.burst);
      wait_val  = (run_now_ff >= burst_ext) ? run_now_ff - burst_ext : '0;
   end

   // configuration write
   assign csr_ch.ready = 1'b1;
   assign quantum_in   = csr_ch.valid ? csr_ch.time_quantum : quantum_ff;

   // second step: commit the operation and build the response beat
   always_comb begin
      count_in      = count_ff;
      loaded_in     = loaded_ff;
      now_in        = now_ff;
      last_valid_in = last_valid_ff;
      last_job_in   = last_job_ff;
      started_in    = started_ff;
      sum_turn_in   = sum_turn_ff;
      sum_wait_in   = sum_wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      beat_in       = beat_ff;
      q_shift       = 1'b0;
      q_push        = 1'b0;
      q_push_pos    = count_ff;
      q_push_data   = '{idx: loaded_ff[JOB_W-1:0], rem: burst_ff, burst: burst_ff};

      if (commit_go) begin
         unique case (func_ff)
            FUNC_LOAD: begin
               if (!started_ff && (loaded_ff < COUNT_W'(MAX_JOBS))) begin
                  q_push            = 1'b1;
                  count_in          = count_ff + 1'b1;
                  loaded_in         = loaded_ff + 1'b1;
                  rsp_valid_in      = 1'b1;
                  beat_in           = '0;
                  beat_in.job_index = JOB_INDEX_W'(loaded_ff);
                  beat_in.jobs_left = LEFT_W'(count_ff + 1'b1);
               end
            end
            FUNC_DISPATCH: begin
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               beat_in      = '0;
               if (count_ff == '0) begin
                  beat_in.queue_empty = 1'b1;
               end else begin
                  q_shift                  = 1'b1;
                  now_in                   = run_now_ff;
                  last_valid_in            = 1'b1;
                  last_job_in              = head.idx;
                  beat_in.job_index        = JOB_INDEX_W'(head.idx);
                  beat_in.slice_start      = now_ff[TIME_W-1:0];
                  beat_in.slice_end        = run_now_ff[TIME_W-1:0];
                  beat_in.extends_previous = last_valid_ff && (last_job_ff == head.idx);
                  if (rem_left_ff != '0) begin
                     // requeue behind the others after the shift
                     q_push      = 1'b1;
                     q_push_pos  = count_ff - 1'b1;
                     q_push_data = '{idx: head.idx, rem: rem_left_ff, burst: head.burst};
                  end else begin
                     count_in                = count_ff - 1'b1;
                     sum_turn_in             = sum_turn_ff + TOTAL_W'(run_now_ff);
                     sum_wait_in             = sum_wait_ff + TOTAL_W'(wait_val);
                     beat_in.job_finished    = 1'b1;
                     beat_in.completion_time = run_now_ff[TIME_W-1:0];
                     beat_in.waiting_time    = wait_val[TIME_W-1:0];
                  end
                  beat_in.total_turnaround = sum_turn_in;
                  beat_in.total_waiting    = sum_wait_in;
               end
               beat_in.jobs_left = LEFT_W'(count_in);
            end
            FUNC_CLEAR: begin
               count_in      = '0;
               loaded_in     = '0;
               now_in        = '0;
               last_valid_in = 1'b0;
               last_job_in   = '0;
               started_in    = 1'b0;
               sum_turn_in   = '0;
               sum_wait_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         loaded_ff     <= '0;
         now_ff        <= '0;
         last_valid_ff <= 1'b0;
         last_job_ff   <= '0;
         started_ff    <= 1'b0;
         sum_turn_ff   <= '0;
         sum_wait_ff   <= '0;
         quantum_ff    <= QUANTUM_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         loaded_ff     <= loaded_in;
         now_ff        <= now_in;
         last_valid_ff <= last_valid_in;
         last_job_ff   <= last_job_in;
         started_ff    <= started_in;
         sum_turn_ff   <= sum_turn_in;
         sum_wait_ff   <= sum_wait_in;
         quantum_ff    <= quantum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      burst_ff    <= burst_in;
      run_now_ff  <= run_now_in;
      rem_left_ff <= rem_left_in;
      beat_ff     <= beat_in;
   end

   // response channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.queue_empty      = beat_ff.queue_empty;
   assign rsp_ch.job_index        = beat_ff.job_index;
   assign rsp_ch.slice_start      = beat_ff.slice_start;
   assign rsp_ch.slice_end        = beat_ff.slice_end;
   assign rsp_ch.extends_previous = beat_ff.extends_previous;
   assign rsp_ch.job_finished     = beat_ff.job_finished;
   assign rsp_ch.completion_time  = beat_ff.completion_time;
   assign rsp_ch.waiting_time     = beat_ff.waiting_time;
   assign rsp_ch.total_turnaround = beat_ff.total_turnaround;
   assign rsp_ch.total_waiting    = beat_ff.total_waiting;
   assign rsp_ch.jobs_left        = beat_ff.jobs_left;

endmodule

`default_nettype wire
